### rtl/lce_pkg.sv
`default_nettype none

package lce_pkg;

    localparam int ITEM_W = 8;

    // Configuration register indexes (word address bits)
    localparam logic REG_DECODE_MODE = 1'b0;

    // One transaction as it moves along the row of cells
    typedef struct packed {
        logic              valid;
        logic              mode;
        logic              last;
        logic [ITEM_W-1:0] value;
        logic              found;
        logic [ITEM_W-1:0] result;
    } lce_tok_t;

endpackage

`default_nettype wire

### rtl/lce_cell.sv
`default_nettype none

module lce_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire lce_pkg::lce_tok_t tok_i,
    input  wire logic [CNT_W-1:0]  cnt_i,
    output lce_pkg::lce_tok_t      tok_o,
    output logic [CNT_W-1:0]       cnt_o
);
    import lce_pkg::*;

    localparam int CMP_W = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;
    localparam logic [CMP_W-1:0]  K_CMP = CMP_W'(INDEX);
    localparam logic [ITEM_W-1:0] K_LOW = ITEM_W'(INDEX);

    lce_tok_t         tok_reg, tok_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             used_reg, used_next;

    logic [CMP_W-1:0] val_x;
    logic [CMP_W-1:0] cnt_x;
    logic             enc_hit;
    logic             enc_below;
    logic             dec_free;
    logic             dec_hit;
    logic             mark;

    always_comb begin
        val_x     = CMP_W'(tok_i.value);
        cnt_x     = CMP_W'(cnt_i);
        enc_hit   = !tok_i.mode && (val_x == K_CMP) && !used_reg;
        enc_below = !tok_i.mode && (val_x > K_CMP) && !used_reg;
        dec_free  = tok_i.mode && !tok_i.found && !used_reg;
        dec_hit   = dec_free && (cnt_x == val_x);
        mark      = enc_hit || dec_hit;

        tok_next = tok_i;
        cnt_next = cnt_i;
        if (mark) begin
            tok_next.found = 1'b1;
        end
        if (dec_hit) begin
            tok_next.result = K_LOW;
        end
        // count free values below the element, or free values skipped by rank
        if (enc_below || (dec_free && !dec_hit)) begin
            cnt_next = cnt_i + CNT_W'(1);
        end

        used_next = used_reg;
        if (tok_i.valid) begin
            if (tok_i.last) begin
                used_next = 1'b0;
            end else if (mark) begin
                used_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            used_reg      <= 1'b0;
        end else if (adv) begin
            tok_reg  <= tok_next;
            cnt_reg  <= cnt_next;
            used_reg <= used_next;
        end
    end

    assign tok_o = tok_reg;
    assign cnt_o = cnt_reg;

endmodule

`default_nettype wire

### rtl/lehmer_code_encode_decode_core.sv
`default_nettype none
// From input accept to result valid a transaction passes through every registered cell.
// Throughput: one transaction per cycle unless the result side stalls; each cell
// holds one bitmap bit and updates it before the following transaction reaches it.
// A stall on the result side freezes the whole row of cells.
// Reset (synchronous, aresetn low) clears the bitmap, the pipeline and decode_mode.

module lehmer_code_encode_decode_core #(
    parameter int SIZE_N = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [lce_pkg::ITEM_W-1:0] s_item_value,
    input  wire logic        s_last_item,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [lce_pkg::ITEM_W-1:0] m_result_value,
    output logic             m_error_flag,
    output logic             m_result_last
);
    import lce_pkg::*;

    localparam int CNT_W = $clog2(SIZE_N + 1);
    localparam int CMP_W = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;

    logic decode_mode_reg, decode_mode_next;
    logic adv;
    logic cfg_wr;

    lce_tok_t         tok_chain [SIZE_N+1];
    logic [CNT_W-1:0] cnt_chain [SIZE_N+1];
    lce_tok_t         tok_out;
    logic [CNT_W-1:0] cnt_out;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        decode_mode_next = decode_mode_reg;
        if (cfg_wr && (paddr[2] == REG_DECODE_MODE)) begin
            decode_mode_next = pwdata[0];
        end
        prdata = '0;
        if (paddr[2] == REG_DECODE_MODE) begin
            prdata = {31'b0, decode_mode_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg <= 1'b0;
        end else begin
            decode_mode_reg <= decode_mode_next;
        end
    end

    // advance the row whenever the output stage is free or being drained
    assign adv     = !tok_out.valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        tok_chain[0].valid  = s_valid;
        tok_chain[0].mode   = decode_mode_reg;
        tok_chain[0].last   = s_last_item;
        tok_chain[0].value  = s_item_value;
        tok_chain[0].found  = 1'b0;
        tok_chain[0].result = '0;
        cnt_chain[0]        = '0;
    end

    for (genvar i = 0; i < SIZE_N; i++) begin : gen_cell
        lce_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_i   (tok_chain[i]),
            .cnt_i   (cnt_chain[i]),
            .tok_o   (tok_chain[i+1]),
            .cnt_o   (cnt_chain[i+1])
        );
    end

    assign tok_out = tok_chain[SIZE_N];
    assign cnt_out = cnt_chain[SIZE_N];

    always_comb begin
        m_valid       = tok_out.valid;
        m_error_flag  = !tok_out.found;
        m_result_last = tok_out.last;
        if (!tok_out.found) begin
            m_result_value = '0;
        end else if (tok_out.mode) begin
            m_result_value = tok_out.result;
        end else begin
            m_result_value = ITEM_W'(cnt_out);
        end
    end

    // a stalled row must not move its first cell
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(tok_chain[1]) && $stable(cnt_chain[1]))
        else $error("cell row moved during a stall");

    // an encoded digit never exceeds the element it came from
    a_enc_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !tok_out.mode && tok_out.found) |->
            (CMP_W'(cnt_out) <= CMP_W'(tok_out.value)))
        else $error("encode digit above element");

    // a decoded hit skipped exactly as many free values as the digit asks
    a_dec_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && tok_out.mode && tok_out.found) |->
            (CMP_W'(cnt_out) == CMP_W'(tok_out.value)))
        else $error("decode rank mismatch");

endmodule

`default_nettype wire
